### src/pacs_pkg.sv
// pacs_pkg: shared widths, register indexes, reset values and the
// controller/datapath command and status types of the pedal axis scaler
// depends on nothing
`timescale 1ns / 1ps

package pacs_pkg;

   localparam int SAMPLE_W = 12;
   localparam int SCALE_W  = 16;
   localparam int PROD_W   = SAMPLE_W + SCALE_W;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam int DIV_STEPS = SCALE_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [SAMPLE_W-1:0] SAMPLE_CAP = 12'hffe;

   localparam logic [SCALE_W-1:0]  SCALE_RESET   = 16'hffff;
   localparam logic [SAMPLE_W-1:0] MINIMUM_RESET = 12'h000;
   localparam logic [SAMPLE_W-1:0] MAXIMUM_RESET = 12'hfff;

   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_MIN   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LEARN_MAX   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER_DZ    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER_DZ    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_SCALE   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_MIN    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_INIT_MAX    = 3'd6;

   typedef struct packed {
      logic load;
      logic prep;
      logic mul;
      logic out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
   } dp_sts_type;

endpackage

### src/pacs_req_if.sv
// pacs_req_if: input channel carrying one raw pedal sample per word
// depends on pacs_pkg
`timescale 1ns / 1ps

interface pacs_req_if;
   import pacs_pkg::*;

   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

### src/pacs_rsp_if.sv
// pacs_rsp_if: result channel carrying the scaled axis value and the learned bounds
// depends on pacs_pkg
`timescale 1ns / 1ps

interface pacs_rsp_if;
   import pacs_pkg::*;

   logic                valid;
   logic                ready;
   logic [SCALE_W-1:0]  axis_value;
   logic [SAMPLE_W-1:0] current_minimum;
   logic [SAMPLE_W-1:0] current_maximum;

   modport source (output valid, output axis_value, output current_minimum,
                   output current_maximum, input ready);
   modport sink   (input valid, input axis_value, input current_minimum,
                   input current_maximum, output ready);
endinterface

### src/pacs_div.sv
// pacs_div: restoring divider, one quotient bit per cycle, 16-bit quotient
// expects dividend < divisor * 2^16; depends on pacs_pkg
`timescale 1ns / 1ps

module pacs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [pacs_pkg::PROD_W-1:0]   dividend,
   input  logic [pacs_pkg::SAMPLE_W-1:0] divisor,
   output logic                          done,
   output logic [pacs_pkg::SCALE_W-1:0]  quotient
);
   import pacs_pkg::*;

   logic [SAMPLE_W-1:0]  rem_ff, rem_in;
   logic [SCALE_W-1:0]   shf_ff, shf_in;
   logic [SAMPLE_W-1:0]  dvs_ff, dvs_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [SAMPLE_W:0]    trial;
   logic [SAMPLE_W:0]    diff;
   logic                 ge;

   always_comb begin
      trial = {rem_ff, shf_ff[SCALE_W-1]};
      diff  = trial - {1'b0, dvs_ff};
      ge    = (trial >= {1'b0, dvs_ff});

      rem_in  = rem_ff;
      shf_in  = shf_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = dividend[PROD_W-1:SCALE_W];
         shf_in  = dividend[SCALE_W-1:0];
         dvs_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[SAMPLE_W-1:0] : trial[SAMPLE_W-1:0];
         shf_in = {shf_ff[SCALE_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      shf_ff <= shf_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = shf_ff;

endmodule

### src/pacs_dp.sv
// pacs_dp: configuration registers, learned travel bounds, clamp, travel
// window, multiplier, divider and result register; depends on pacs_pkg, pacs_div
`timescale 1ns / 1ps

module pacs_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [pacs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pacs_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic [pacs_pkg::SAMPLE_W-1:0]   sample,
   input  pacs_pkg::dp_cmd_type            cmd,
   output pacs_pkg::dp_sts_type            sts,
   output logic [pacs_pkg::SCALE_W-1:0]    axis_value,
   output logic [pacs_pkg::SAMPLE_W-1:0]   current_minimum,
   output logic [pacs_pkg::SAMPLE_W-1:0]   current_maximum
);
   import pacs_pkg::*;

   // configuration and learned bounds
   logic                lmin_ff, lmin_in;
   logic                lmax_ff, lmax_in;
   logic [SAMPLE_W-1:0] ldz_ff, ldz_in;
   logic [SAMPLE_W-1:0] udz_ff, udz_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [SAMPLE_W-1:0] tmin_ff, tmin_in;
   logic [SAMPLE_W-1:0] tmax_ff, tmax_in;

   // per-word working registers
   logic [SAMPLE_W-1:0] smp_ff, smp_in;
   logic [SAMPLE_W-1:0] avail_ff, avail_in;
   logic [SAMPLE_W-1:0] offset_ff, offset_in;
   logic                zero_ff, zero_in;
   logic                sat_ff, sat_in;
   logic [SCALE_W-1:0]  axis_ff, axis_in;
   logic [SAMPLE_W-1:0] omin_ff, omin_in;
   logic [SAMPLE_W-1:0] omax_ff, omax_in;

   logic [SAMPLE_W-1:0] cap_w;
   logic [SAMPLE_W:0]   start_w;
   logic [SAMPLE_W-1:0] end_w;
   logic [SAMPLE_W:0]   avail_w;
   logic [SAMPLE_W:0]   used_w;
   logic [PROD_W-1:0]   prod_w;
   logic [SCALE_W-1:0]  quot_w;
   logic                div_done;

   always_comb begin
      lmin_in  = lmin_ff;
      lmax_in  = lmax_ff;
      ldz_in   = ldz_ff;
      udz_in   = udz_ff;
      scale_in = scale_ff;
      tmin_in  = tmin_ff;
      tmax_in  = tmax_ff;
      smp_in   = smp_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_LEARN_MIN: lmin_in  = csr_wdata[0];
            CSR_LEARN_MAX: lmax_in  = csr_wdata[0];
            CSR_LOWER_DZ:  ldz_in   = csr_wdata[SAMPLE_W-1:0];
            CSR_UPPER_DZ:  udz_in   = csr_wdata[SAMPLE_W-1:0];
            CSR_OUT_SCALE: scale_in = csr_wdata[SCALE_W-1:0];
            CSR_INIT_MIN:  tmin_in  = csr_wdata[SAMPLE_W-1:0];
            CSR_INIT_MAX:  tmax_in  = csr_wdata[SAMPLE_W-1:0];
            default: ;
         endcase
      end else if (cmd.load) begin
         // widen the bound or clamp to it
         smp_in = sample;
         if (sample > tmax_ff) begin
            if (lmax_ff) begin
               tmax_in = sample;
            end else begin
               smp_in = tmax_ff;
            end
         end else if (sample < tmin_ff) begin
            if (lmin_ff) begin
               tmin_in = sample;
            end else begin
               smp_in = tmin_ff;
            end
         end
      end
   end

   // travel window
   always_comb begin
      cap_w = SAMPLE_CAP - ldz_ff;
      if (ldz_ff <= SAMPLE_CAP) begin
         start_w = (tmin_ff < cap_w) ? ({1'b0, tmin_ff} + {1'b0, ldz_ff}) : {1'b0, cap_w};
      end else begin
         start_w = {1'b0, tmin_ff} + {1'b0, ldz_ff};
      end
      end_w   = (tmax_ff >= udz_ff) ? (tmax_ff - udz_ff) : udz_ff;
      avail_w = {1'b0, end_w} - start_w;
      used_w  = {1'b0, ldz_ff} + {1'b0, udz_ff};

      avail_in  = cmd.prep ? avail_w[SAMPLE_W-1:0] : avail_ff;
      zero_in   = cmd.prep ? (({1'b0, end_w} < start_w) || (avail_w < used_w)
                              || (avail_w == '0)) : zero_ff;
      offset_in = offset_ff;
      if (cmd.prep) begin
         offset_in = ({1'b0, smp_ff} >= start_w) ? (smp_ff - start_w[SAMPLE_W-1:0]) : '0;
      end

      prod_w = PROD_W'(offset_ff) * PROD_W'(scale_ff);
      sat_in = cmd.mul ? (offset_ff >= avail_ff) : sat_ff;

      axis_in = axis_ff;
      omin_in = omin_ff;
      omax_in = omax_ff;
      if (cmd.out_load) begin
         if (zero_ff) begin
            axis_in = '0;
         end else if (sat_ff) begin
            axis_in = scale_ff;
         end else begin
            axis_in = quot_w;
         end
         omin_in = tmin_ff;
         omax_in = tmax_ff;
      end
   end

   pacs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.mul),
      .dividend (prod_w),
      .divisor  (avail_ff),
      .done     (div_done),
      .quotient (quot_w)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         lmin_ff  <= 1'b0;
         lmax_ff  <= 1'b0;
         ldz_ff   <= '0;
         udz_ff   <= '0;
         scale_ff <= SCALE_RESET;
         tmin_ff  <= MINIMUM_RESET;
         tmax_ff  <= MAXIMUM_RESET;
      end else begin
         lmin_ff  <= lmin_in;
         lmax_ff  <= lmax_in;
         ldz_ff   <= ldz_in;
         udz_ff   <= udz_in;
         scale_ff <= scale_in;
         tmin_ff  <= tmin_in;
         tmax_ff  <= tmax_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff    <= smp_in;
      avail_ff  <= avail_in;
      offset_ff <= offset_in;
      zero_ff   <= zero_in;
      sat_ff    <= sat_in;
      axis_ff   <= axis_in;
      omin_ff   <= omin_in;
      omax_ff   <= omax_in;
   end

   assign sts.div_done     = div_done;
   assign axis_value      = axis_ff;
   assign current_minimum = omin_ff;
   assign current_maximum = omax_ff;

endmodule

### src/pacs_ctrl.sv
// pacs_ctrl: sequencing state machine and result valid flag
// depends on pacs_pkg
`timescale 1ns / 1ps

module pacs_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  pacs_pkg::dp_sts_type sts,
   output pacs_pkg::dp_cmd_type cmd
);
   import pacs_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_PREP = 5'b00010,
      S_MUL  = 5'b00100,
      S_DIV  = 5'b01000,
      S_WB   = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic      rvalid_ff, rvalid_in;
   logic      out_free;

   always_comb begin
      out_free = !rvalid_ff || rsp_ready;
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PREP;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_WB;
            end
         end
         S_WB: begin
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (cmd.out_load) begin
         rvalid_in = 1'b1;
      end else if (rsp_ready) begin
         rvalid_in = 1'b0;
      end else begin
         rvalid_in = rvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         rvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rvalid_ff <= rvalid_in;
      end
   end

   assign rsp_valid = rvalid_ff;

endmodule

### src/pedal_axis_calibrated_scaler.sv
// pedal_axis_calibrated_scaler: self-calibrating pedal axis scaler with deadzones
// one sample word is in progress at a time, through the 16-step serial divider
// the result register lets the next sample in while a result waits
// reset: synchronous; config registers return to defaults, bounds to 0 and 4095
// depends on pacs_pkg, pacs_req_if, pacs_rsp_if, pacs_ctrl, pacs_dp
`timescale 1ns / 1ps

module pedal_axis_calibrated_scaler (
   input  logic                            clock,
   input  logic                            reset,
   pacs_req_if.sink                        req_bus,
   pacs_rsp_if.source                      rsp_bus,
   input  logic                            csr_we,
   input  logic [pacs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pacs_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import pacs_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;

   pacs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pacs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .sample          (req_bus.sample),
      .cmd             (cmd),
      .sts             (sts),
      .axis_value      (rsp_bus.axis_value),
      .current_minimum (rsp_bus.current_minimum),
      .current_maximum (rsp_bus.current_maximum)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("sample word accepted while previous word in progress");

   a_load_into_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("result register overwritten before being taken");

   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.prep, cmd.mul, cmd.out_load}))
      else $error("more than one datapath command at once");

endmodule
